FILE: sv/tlc_pkg.sv
// Package for the two-way LRU cache tag lookup: address field widths,
// set geometry and the sequencer state type.
// Depends on nothing; the top level imports it.
package tlc_pkg;

	localparam int unsigned AddrBits   = 32;
	localparam int unsigned OffsetBits = 5;
	localparam int unsigned SetBits    = 6;
	localparam int unsigned NumSets    = 1 << SetBits;
	localparam int unsigned BlockBits  = AddrBits - OffsetBits;
	localparam int unsigned TagBits    = BlockBits - SetBits;

	typedef logic [AddrBits-1:0]   addr_t;
	typedef logic [OffsetBits-1:0] offset_t;
	typedef logic [BlockBits-1:0]  block_t;
	typedef logic [SetBits-1:0]    set_t;
	typedef logic [TagBits-1:0]    tag_t;

	// One row of the tag store: both ways of a set.
	typedef struct packed {
		tag_t way1;
		tag_t way0;
	} tag_row_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP0,
		ST_CMP1,
		ST_DONE
	} seq_state_t;

endpackage

FILE: sv/two_way_lru_cache_tag_lookup.sv
// Tag directory of a two-way set-associative cache with LRU replacement.
// Holds the tag store, the per-set valid and recency bits and the lookup sequencer.
// Depends on tlc_pkg.

// A request is taken at a rising edge with start high and busy low; its
// byte address is split into offset, block number, set index and tag, and
// the tag is checked against both ways of the set. The result appears on
// the result ports for exactly one cycle, marked by done, once the request
// has passed CMP0, CMP1 and DONE; the receiver cannot stall it, so it must
// be ready to capture the result in that cycle. Busy is high in CMP0, CMP1
// and DONE and drops in the cycle in which done is shown, so a new request
// may be taken then, but not before the last one is through. That pace is
// set by the single tag store read port (one registered read per request)
// and by the one shared tag comparator, which checks way 0 and way 1 in
// successive cycles before the update cycle. Empty ways are filled first,
// way 0 then way 1; a miss in a full set replaces the way that was not most
// recently used and reports its old tag. Valid and recency bits clear at
// reset, so no clearing pass is needed; the tag store itself is not
// cleared, and a way only counts as a hit once it is filled.
module two_way_lru_cache_tag_lookup (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  tlc_pkg::addr_t   byte_address,
	output logic             done,
	output tlc_pkg::offset_t byte_offset,
	output tlc_pkg::block_t  block_number,
	output tlc_pkg::set_t    set_index,
	output logic             way_used,
	output tlc_pkg::tag_t    line_tag,
	output logic             is_miss,
	output logic             did_replace,
	output tlc_pkg::tag_t    evicted_tag
);
	import tlc_pkg::*;

	// Sequencer state.
	seq_state_t state_q, state_d;

	// The request being worked on.
	addr_t addr_q;
	set_t  set_w;
	tag_t  tag_w;

	// Tag store: one row per set, read and written in clocked blocks.
	tag_row_t tag_mem [NumSets];
	tag_row_t rd_row_q;

	// Per-set state that resets: the two valid bits stand for the fill
	// count, and recent_q holds the most recently used way.
	logic [NumSets-1:0] valid0_q;
	logic [NumSets-1:0] valid1_q;
	logic [NumSets-1:0] recent_q;

	// Shared comparator and its registered results.
	tag_t cmp_operand;
	logic cmp_equal;
	logic hit0_q;
	logic hit1_q;

	// Update decision, worked out in the last cycle of a request.
	logic     cur_valid0;
	logic     cur_valid1;
	logic     cur_recent;
	logic     dec_way;
	logic     dec_miss;
	logic     dec_replace;
	tag_t     dec_evicted;
	logic     dec_write;
	tag_row_t new_row;

	// Result registers.
	logic done_q;
	logic way_q;
	logic miss_q;
	logic replace_q;
	tag_t evicted_q;

	assign set_w = addr_q[OffsetBits +: SetBits];
	assign tag_w = addr_q[OffsetBits + SetBits +: TagBits];

	// The sequencer: accept, compare way 0, compare way 1, update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CMP0;
				end
			end
			ST_CMP0: state_d = ST_CMP1;
			ST_CMP1: state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// Capture the address and read the set's row as the request is taken.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			addr_q   <= byte_address;
			rd_row_q <= tag_mem[byte_address[OffsetBits +: SetBits]];
		end
	end

	// One comparator serves both ways: way 0 in the first compare cycle,
	// way 1 in the second.
	assign cmp_operand = (state_q == ST_CMP0) ? rd_row_q.way0 : rd_row_q.way1;
	assign cmp_equal   = (cmp_operand == tag_w);

	always_ff @(posedge clk) begin
		if (state_q == ST_CMP0) begin
			hit0_q <= cmp_equal;
		end
		if (state_q == ST_CMP1) begin
			hit1_q <= cmp_equal;
		end
	end

	// Hit, fill or replace. A way only counts as a hit once it is filled,
	// and way 0 wins when both ways match.
	always_comb begin
		cur_valid0  = valid0_q[set_w];
		cur_valid1  = valid1_q[set_w];
		cur_recent  = recent_q[set_w];
		dec_way     = 1'b0;
		dec_miss    = 1'b0;
		dec_replace = 1'b0;
		dec_evicted = '0;
		dec_write   = 1'b0;
		new_row     = rd_row_q;
		if (cur_valid0 && hit0_q) begin
			dec_way = 1'b0;
		end else if (cur_valid0 && cur_valid1 && hit1_q) begin
			dec_way = 1'b1;
		end else begin
			dec_miss  = 1'b1;
			dec_write = 1'b1;
			if (!cur_valid0) begin
				dec_way = 1'b0;
			end else if (!cur_valid1) begin
				dec_way = 1'b1;
			end else begin
				// Full set: evict the way that was not used last.
				dec_replace = 1'b1;
				dec_way     = ~cur_recent;
				dec_evicted = cur_recent ? rd_row_q.way0 : rd_row_q.way1;
			end
			if (dec_way) begin
				new_row.way1 = tag_w;
			end else begin
				new_row.way0 = tag_w;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && dec_write) begin
			tag_mem[set_w] <= new_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid0_q <= '0;
			valid1_q <= '0;
			recent_q <= '0;
		end else if (state_q == ST_DONE) begin
			recent_q[set_w] <= dec_way;
			if (dec_write && !dec_way) begin
				valid0_q[set_w] <= 1'b1;
			end
			if (dec_write && dec_way) begin
				valid1_q[set_w] <= 1'b1;
			end
		end
	end

	// The result is registered at the update and shown in the cycle after it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_DONE);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE) begin
			way_q     <= dec_way;
			miss_q    <= dec_miss;
			replace_q <= dec_replace;
			evicted_q <= dec_evicted;
		end
	end

	assign done         = done_q;
	assign byte_offset  = addr_q[OffsetBits-1:0];
	assign block_number = addr_q[AddrBits-1:OffsetBits];
	assign set_index    = set_w;
	assign line_tag     = tag_w;
	assign way_used     = way_q;
	assign is_miss      = miss_q;
	assign did_replace  = replace_q;
	assign evicted_tag  = evicted_q;

	// A result is only shown once the sequencer has gone back to idle.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result shown while a request is still in progress");

	// An accepted request keeps the block busy in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("request accepted but block not busy afterwards");

	// The update cycle is always followed by the result strobe.
	assert property (@(posedge clk) disable iff (!arst_n) (state_q == ST_DONE) |=> done)
		else $error("update cycle not followed by a result");

	// A replacement is always a miss.
	assert property (@(posedge clk) disable iff (!arst_n) (done && did_replace) |-> is_miss)
		else $error("replacement reported on a hit");

endmodule
